// ===== rtl/pdds_pkg.sv =====
// ----------------------------------------------------------------------------
// pdds_pkg: shared definitions of the planar drone dynamics step
// Fixed-point format, trig constants, the arctangent table, command and
// register codes, state types and the saturation helper.
// ----------------------------------------------------------------------------
package pdds_pkg;

  // number format
  localparam int FRAC_BITS  = 16;
  localparam int TRIG_STEPS = 16;
  localparam int DATA_W     = 32;
  localparam int CFG_W      = 31;
  localparam int CFG_IDX_W  = 3;
  localparam int CNT_W      = 5;

  // trig datapath widths
  localparam int Z_W   = 36;
  localparam int XY_W  = 34;
  localparam int REM_W = 33;

  // pi at FRAC_BITS, rounded to nearest, and the Q2.30 constants
  localparam longint PI_Q32    = 64'sd13493037705;
  localparam longint PI_Q      = (PI_Q32 + (64'sd1 <<< (31 - FRAC_BITS))) >>> (32 - FRAC_BITS);
  localparam longint TWO_PI_Q  = 2 * PI_Q;
  localparam longint PI30      = 64'sd3373259426;
  localparam longint HALF_PI30 = 64'sd1686629713;
  localparam longint GAIN30    = 64'sh26DD3B6A;

  // commands
  localparam logic [1:0] CMD_SET  = 2'd0;
  localparam logic [1:0] CMD_STEP = 2'd1;
  localparam logic [1:0] CMD_LOAD = 2'd2;

  // register indices
  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INV_MASS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GRAVITY     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_ARM    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INV_INERTIA = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_THRUST_MAX  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_THRUST_MIN  = 3'd6;

  // multiply chain steps
  localparam logic [3:0] OP_LAST = 4'd11;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TRIG,
    ST_MUL_GO,
    ST_MUL_WAIT,
    ST_OUT
  } top_state_e;

  typedef enum logic [2:0] {
    TR_IDLE,
    TR_MOD,
    TR_FOLD,
    TR_ROT,
    TR_DONE
  } trig_state_e;

  // arctangent of 2^-i in Q2.30
  function automatic logic signed [Z_W-1:0] atan_lut(input logic [CNT_W-1:0] i);
    logic signed [Z_W-1:0] v;
    case (i)
      5'd0:  v = 36'sh03243F6A8;
      5'd1:  v = 36'sh01DAC6705;
      5'd2:  v = 36'sh00FADBAFC;
      5'd3:  v = 36'sh007F56EA6;
      5'd4:  v = 36'sh003FEAB76;
      5'd5:  v = 36'sh001FFD55B;
      5'd6:  v = 36'sh000FFFAAA;
      5'd7:  v = 36'sh0007FFF55;
      5'd8:  v = 36'sh0003FFFEA;
      5'd9:  v = 36'sh0001FFFFD;
      5'd10: v = 36'sh0000FFFFF;
      5'd11: v = 36'sh00007FFFF;
      5'd12: v = 36'sh00003FFFF;
      5'd13: v = 36'sh00001FFFF;
      5'd14: v = 36'sh00000FFFF;
      5'd15: v = 36'sh000007FFF;
      5'd16: v = 36'sh000003FFF;
      5'd17: v = 36'sh000001FFF;
      5'd18: v = 36'sh000000FFF;
      5'd19: v = 36'sh0000007FF;
      5'd20: v = 36'sh0000003FF;
      5'd21: v = 36'sh0000001FF;
      5'd22: v = 36'sh0000000FF;
      5'd23: v = 36'sh00000007F;
      default: v = '0;
    endcase
    return v;
  endfunction

  // clip a wide signed value to 32-bit signed
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > 64'sh000000007FFFFFFF) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -64'sh0000000080000000) begin
      r = 32'sh80000000;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/planar_drone_dynamics_step.sv =====
// ----------------------------------------------------------------------------
// planar_drone_dynamics_step: planar two-rotor drone, one Euler step per step word
// Q16.16 rigid-body state stepped by a sequencer over a serial multiplier.
// ----------------------------------------------------------------------------
// Usage:
//  - Input words arrive on s_axis; each carries a command and its operands.
//    Set-thrust and load-position words, and unused codes, go from idle straight to the output state.
//  - A step word runs the angle reduction, fold, 16 CORDIC rotations and
//    hand-off, then twelve chained products on the bit-serial multiplier,
//    each from its own start state. The multiplier is the limiting unit.
//  - Every word returns one result word on m_axis holding position,
//    velocity, angle and rate after the word.
//  - One word is in work at a time; s_axis_tready is high only while idle.
//    A finished result sits in the output register; a stalled receiver holds
//    the next finished word in the sequencer until the register frees.
//  - Registers are to be written on the cfg port only while the block is idle,
//    a rule for the user that the block does not enforce; cfg_ready_o is always high.
//  - Reset clears the state to zero and loads the default registers.
// ----------------------------------------------------------------------------
module planar_drone_dynamics_step (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // command[1:0], left_thrust[33:2], right_thrust[65:34], reset_x[97:66],
  // reset_y[129:98], zero fill to 136
  input  logic [135:0]                       s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // out_pos_x[31:0], out_pos_y[63:32], out_vel_x[95:64], out_vel_y[127:96],
  // out_angle[159:128], out_rate[191:160]
  output logic [191:0]                       m_axis_tdata,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [pdds_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [pdds_pkg::CFG_W-1:0]         cfg_data_i
);

  localparam int W = pdds_pkg::DATA_W;

  pdds_pkg::top_state_e st_q, st_d;

  // configuration
  logic [pdds_pkg::CFG_W-1:0] dt_q, imass_q, grav_q, arm_q, iinert_q, tmax_q, tmin_q;

  // body state
  logic signed [W-1:0] px_q, py_q, vx_q, vy_q, tilt_q, spin_q, hl_q, hr_q;
  logic signed [W-1:0] tot_q, dif_q, sin_q, cos_q, t1_q;
  logic [3:0]          op_q;
  logic                out_vld_q;
  logic [191:0]        out_q;

  // input fields
  logic [1:0]          cmd;
  logic signed [W-1:0] in_l, in_r, in_x, in_y;
  logic                in_acc;
  logic                out_free;
  logic                trig_start, trig_done, mul_start, mul_done;
  logic signed [W-1:0] trig_sin, trig_cos, mul_a, mul_b, mul_p;
  logic signed [W-1:0] cl_l, cl_r;

  assign cmd  = s_axis_tdata[1:0];
  assign in_l = s_axis_tdata[33:2];
  assign in_r = s_axis_tdata[65:34];
  assign in_x = s_axis_tdata[97:66];
  assign in_y = s_axis_tdata[129:98];

  assign in_acc      = s_axis_tvalid && s_axis_tready;
  assign out_free    = !out_vld_q || m_axis_tready;
  assign cfg_ready_o = 1'b1;

  // thrust clamp, max first then min
  function automatic logic signed [W-1:0] clamp(input logic signed [W-1:0] f,
                                                input logic [pdds_pkg::CFG_W-1:0] hi,
                                                input logic [pdds_pkg::CFG_W-1:0] lo);
    logic signed [W:0] a;
    a = (33'(f) > $signed({2'b00, hi})) ? $signed({2'b00, hi}) : 33'(f);
    a = (a < $signed({2'b00, lo})) ? $signed({2'b00, lo}) : a;
    return a[W-1:0];
  endfunction

  assign cl_l = clamp(in_l, tmax_q, tmin_q);
  assign cl_r = clamp(in_r, tmax_q, tmin_q);

  // operand selection for the multiply chain
  always_comb begin
    mul_a = t1_q;
    mul_b = W'(dt_q);
    case (op_q)
      4'd0:  begin mul_a = tot_q;  mul_b = sin_q;        end
      4'd1:  begin mul_a = t1_q;   mul_b = W'(imass_q);  end
      4'd2:  begin mul_a = t1_q;   mul_b = W'(dt_q);     end
      4'd3:  begin mul_a = tot_q;  mul_b = cos_q;        end
      4'd4:  begin mul_a = t1_q;   mul_b = W'(imass_q);  end
      4'd5:  begin mul_a = t1_q;   mul_b = W'(dt_q);     end
      4'd6:  begin mul_a = vx_q;   mul_b = W'(dt_q);     end
      4'd7:  begin mul_a = vy_q;   mul_b = W'(dt_q);     end
      4'd8:  begin mul_a = dif_q;  mul_b = W'(arm_q);    end
      4'd9:  begin mul_a = t1_q;   mul_b = W'(iinert_q); end
      4'd10: begin mul_a = t1_q;   mul_b = W'(dt_q);     end
      4'd11: begin mul_a = spin_q; mul_b = W'(dt_q);     end
      default: ;
    endcase
  end

  pdds_trig u_trig (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (trig_start),
    .angle_i (tilt_q),
    .done_o  (trig_done),
    .sin_o   (trig_sin),
    .cos_o   (trig_cos)
  );

  pdds_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      pdds_pkg::ST_IDLE: begin
        if (in_acc) st_d = (cmd == pdds_pkg::CMD_STEP) ? pdds_pkg::ST_TRIG : pdds_pkg::ST_OUT;
      end
      pdds_pkg::ST_TRIG:     if (trig_done) st_d = pdds_pkg::ST_MUL_GO;
      pdds_pkg::ST_MUL_GO:   st_d = pdds_pkg::ST_MUL_WAIT;
      pdds_pkg::ST_MUL_WAIT: begin
        if (mul_done) st_d = (op_q == pdds_pkg::OP_LAST) ? pdds_pkg::ST_OUT : pdds_pkg::ST_MUL_GO;
      end
      pdds_pkg::ST_OUT:      if (out_free) st_d = pdds_pkg::ST_IDLE;
      default:               st_d = pdds_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    s_axis_tready = (st_q == pdds_pkg::ST_IDLE);
    trig_start    = (st_q == pdds_pkg::ST_IDLE) && in_acc && (cmd == pdds_pkg::CMD_STEP);
    mul_start     = (st_q == pdds_pkg::ST_MUL_GO);
  end

  // config, state machine and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= pdds_pkg::ST_IDLE;
      out_vld_q <= 1'b0;
      out_q     <= '0;
      op_q      <= '0;
      t1_q      <= '0;
      dt_q      <= 31'd1092;
      imass_q   <= 31'd65536;
      grav_q    <= 31'd642908;
      arm_q     <= 31'd32768;
      iinert_q  <= 31'd65536;
      tmax_q    <= 31'd1157234;
      tmin_q    <= 31'd128582;
      px_q      <= '0;
      py_q      <= '0;
      vx_q      <= '0;
      vy_q      <= '0;
      tilt_q    <= '0;
      spin_q    <= '0;
      hl_q      <= '0;
      hr_q      <= '0;
    end else begin
      st_q <= st_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          pdds_pkg::REG_TIME_STEP:   dt_q     <= cfg_data_i;
          pdds_pkg::REG_INV_MASS:    imass_q  <= cfg_data_i;
          pdds_pkg::REG_GRAVITY:     grav_q   <= cfg_data_i;
          pdds_pkg::REG_HALF_ARM:    arm_q    <= cfg_data_i;
          pdds_pkg::REG_INV_INERTIA: iinert_q <= cfg_data_i;
          pdds_pkg::REG_THRUST_MAX:  tmax_q   <= cfg_data_i;
          pdds_pkg::REG_THRUST_MIN:  tmin_q   <= cfg_data_i;
          default: ;
        endcase
      end
      // result register valid: load when a word finishes, clear when taken
      if ((st_q == pdds_pkg::ST_OUT) && out_free) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
      case (st_q)
        pdds_pkg::ST_IDLE: begin
          op_q <= '0;
          if (in_acc) begin
            case (cmd)
              pdds_pkg::CMD_SET: begin
                hl_q <= cl_l;
                hr_q <= cl_r;
              end
              pdds_pkg::CMD_LOAD: begin
                hl_q   <= '0;
                hr_q   <= '0;
                tilt_q <= '0;
                spin_q <= '0;
                vx_q   <= '0;
                vy_q   <= '0;
                px_q   <= in_x;
                py_q   <= in_y;
              end
              default: ;
            endcase
          end
        end
        pdds_pkg::ST_MUL_WAIT: begin
          if (mul_done) begin
            op_q <= op_q + 1'b1;
            case (op_q)
              4'd2:  vx_q   <= pdds_pkg::sat32(64'(vx_q) + 64'(mul_p));
              4'd4:  t1_q   <= pdds_pkg::sat32(64'(grav_q) - 64'(mul_p));
              4'd5:  vy_q   <= pdds_pkg::sat32(64'(vy_q) + 64'(mul_p));
              4'd6:  px_q   <= pdds_pkg::sat32(64'(px_q) + 64'(mul_p));
              4'd7:  py_q   <= pdds_pkg::sat32(64'(py_q) + 64'(mul_p));
              4'd10: spin_q <= pdds_pkg::sat32(64'(spin_q) + 64'(mul_p));
              4'd11: tilt_q <= pdds_pkg::sat32(64'(tilt_q) + 64'(mul_p));
              default: t1_q <= mul_p;
            endcase
          end
        end
        pdds_pkg::ST_OUT: begin
          if (out_free) begin
            out_q <= {spin_q, tilt_q, vy_q, vx_q, py_q, px_q};
          end
        end
        default: ;
      endcase
    end
  end

  // step operands: thrust sum and difference at step start, sine and cosine at trig done
  always_ff @(posedge clk_i) begin
    if (trig_start) begin
      tot_q <= pdds_pkg::sat32(64'(hl_q) + 64'(hr_q));
      dif_q <= pdds_pkg::sat32(64'(hl_q) - 64'(hr_q));
    end
    if (trig_done) begin
      sin_q <= trig_sin;
      cos_q <= trig_cos;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

endmodule

// ===== rtl/pdds_mul.sv =====
// ----------------------------------------------------------------------------
// pdds_mul: bit-serial fixed-point multiplier
// Shift-and-add over the multiplier bits, one bit per cycle, the sign bit
// subtracted; the product is floor-shifted and saturated.
// ----------------------------------------------------------------------------
module pdds_mul (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [pdds_pkg::DATA_W-1:0]  a_i,
  input  logic signed [pdds_pkg::DATA_W-1:0]  b_i,
  output logic                                done_o,
  output logic signed [pdds_pkg::DATA_W-1:0]  p_o
);

  logic                            run_q;
  logic                            done_q;
  logic [pdds_pkg::CNT_W-1:0]      cnt_q;
  logic signed [63:0]              acc_q;
  logic signed [63:0]              ash_q;
  logic [pdds_pkg::DATA_W-1:0]     bsh_q;
  logic                            last_bit;

  assign last_bit = (cnt_q == pdds_pkg::CNT_W'(pdds_pkg::DATA_W - 1));

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= run_q && !start_i && last_bit;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last_bit) begin
          run_q <= 1'b0;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      ash_q <= 64'(a_i);
      bsh_q <= b_i;
    end else if (run_q) begin
      if (bsh_q[0]) begin
        acc_q <= last_bit ? acc_q - ash_q : acc_q + ash_q;
      end
      ash_q <= ash_q <<< 1;
      bsh_q <= bsh_q >> 1;
    end
  end

  assign done_o = done_q;
  assign p_o    = pdds_pkg::sat32(acc_q >>> pdds_pkg::FRAC_BITS);

endmodule

// ===== rtl/pdds_trig.sv =====
// ----------------------------------------------------------------------------
// pdds_trig: angle reduction and CORDIC sine/cosine
// Restoring remainder by 2*pi one bit per cycle, a fold into the right half
// plane, then one CORDIC rotation per cycle.
// ----------------------------------------------------------------------------
module pdds_trig (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [pdds_pkg::DATA_W-1:0]  angle_i,
  output logic                                done_o,
  output logic signed [pdds_pkg::DATA_W-1:0]  sin_o,
  output logic signed [pdds_pkg::DATA_W-1:0]  cos_o
);

  localparam logic [pdds_pkg::REM_W-1:0] TwoPiRem = pdds_pkg::REM_W'(pdds_pkg::TWO_PI_Q);
  localparam int OutShift = 30 - pdds_pkg::FRAC_BITS;

  pdds_pkg::trig_state_e st_q, st_d;

  logic [pdds_pkg::CNT_W-1:0]        cnt_q;
  logic [pdds_pkg::DATA_W-1:0]       mag_q;
  logic [pdds_pkg::REM_W-1:0]        rem_q;
  logic                              neg_q;
  logic                              flip_q;
  logic signed [pdds_pkg::Z_W-1:0]   z_q;
  logic signed [pdds_pkg::XY_W-1:0]  x_q;
  logic signed [pdds_pkg::XY_W-1:0]  y_q;

  logic [pdds_pkg::REM_W-1:0]        rem_sh;
  logic [pdds_pkg::REM_W-1:0]        rem_nx;
  logic signed [pdds_pkg::Z_W-1:0]   rr;
  logic signed [pdds_pkg::Z_W-1:0]   rw;
  logic signed [pdds_pkg::Z_W-1:0]   zs;
  logic signed [pdds_pkg::Z_W-1:0]   zf;
  logic                              fl;
  logic signed [pdds_pkg::XY_W-1:0]  xs;
  logic signed [pdds_pkg::XY_W-1:0]  ys;
  logic signed [pdds_pkg::XY_W-1:0]  xo;
  logic signed [pdds_pkg::XY_W-1:0]  yo;
  logic                              mod_end;
  logic                              rot_end;

  // remainder step
  always_comb begin
    rem_sh = {rem_q[pdds_pkg::REM_W-2:0], mag_q[pdds_pkg::DATA_W-1]};
    rem_nx = (rem_sh >= TwoPiRem) ? rem_sh - TwoPiRem : rem_sh;
  end

  // signed remainder into (-pi, pi], scale to Q2.30, fold to +-pi/2
  always_comb begin
    rr = (neg_q && (rem_q != '0)) ? pdds_pkg::Z_W'(pdds_pkg::TWO_PI_Q) -
         pdds_pkg::Z_W'(rem_q) : pdds_pkg::Z_W'(rem_q);
    rw = (rr > pdds_pkg::Z_W'(pdds_pkg::PI_Q)) ? rr - pdds_pkg::Z_W'(pdds_pkg::TWO_PI_Q) : rr;
    zs = rw <<< OutShift;
    fl = 1'b0;
    zf = zs;
    if (zs > pdds_pkg::Z_W'(pdds_pkg::HALF_PI30)) begin
      zf = zs - pdds_pkg::Z_W'(pdds_pkg::PI30);
      fl = 1'b1;
    end else if (zs < -pdds_pkg::Z_W'(pdds_pkg::HALF_PI30)) begin
      zf = zs + pdds_pkg::Z_W'(pdds_pkg::PI30);
      fl = 1'b1;
    end
  end

  assign xs      = x_q >>> cnt_q;
  assign ys      = y_q >>> cnt_q;
  assign mod_end = (cnt_q == pdds_pkg::CNT_W'(pdds_pkg::DATA_W - 1));
  assign rot_end = (cnt_q == pdds_pkg::CNT_W'(pdds_pkg::TRIG_STEPS - 1));

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      pdds_pkg::TR_IDLE: if (start_i) st_d = pdds_pkg::TR_MOD;
      pdds_pkg::TR_MOD:  if (mod_end) st_d = pdds_pkg::TR_FOLD;
      pdds_pkg::TR_FOLD: st_d = pdds_pkg::TR_ROT;
      pdds_pkg::TR_ROT:  if (rot_end) st_d = pdds_pkg::TR_DONE;
      pdds_pkg::TR_DONE: st_d = pdds_pkg::TR_IDLE;
      default:           st_d = pdds_pkg::TR_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    done_o = (st_q == pdds_pkg::TR_DONE);
    xo     = x_q >>> OutShift;
    yo     = y_q >>> OutShift;
    if (flip_q) begin
      xo = -xo;
      yo = -yo;
    end
    cos_o = pdds_pkg::sat32(64'(xo));
    sin_o = pdds_pkg::sat32(64'(yo));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= pdds_pkg::TR_IDLE;
      cnt_q <= '0;
    end else begin
      st_q <= st_d;
      case (st_q)
        pdds_pkg::TR_IDLE: cnt_q <= '0;
        pdds_pkg::TR_MOD:  cnt_q <= mod_end ? '0 : cnt_q + 1'b1;
        pdds_pkg::TR_ROT:  cnt_q <= cnt_q + 1'b1;
        default:           cnt_q <= '0;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (st_q)
      pdds_pkg::TR_IDLE: begin
        if (start_i) begin
          neg_q <= angle_i[pdds_pkg::DATA_W-1];
          mag_q <= angle_i[pdds_pkg::DATA_W-1] ? pdds_pkg::DATA_W'(-angle_i) : angle_i;
          rem_q <= '0;
        end
      end
      pdds_pkg::TR_MOD: begin
        rem_q <= rem_nx;
        mag_q <= mag_q << 1;
      end
      pdds_pkg::TR_FOLD: begin
        z_q    <= zf;
        flip_q <= fl;
        x_q    <= pdds_pkg::XY_W'(pdds_pkg::GAIN30);
        y_q    <= '0;
      end
      pdds_pkg::TR_ROT: begin
        if (!z_q[pdds_pkg::Z_W-1]) begin
          x_q <= x_q - ys;
          y_q <= y_q + xs;
          z_q <= z_q - pdds_pkg::atan_lut(cnt_q);
        end else begin
          x_q <= x_q + ys;
          y_q <= y_q - xs;
          z_q <= z_q + pdds_pkg::atan_lut(cnt_q);
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== dv/planar_drone_dynamics_step_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// planar_drone_dynamics_step_test: self-checking bench of the drone step
// Drives command words through s_axis under bursty traffic and a stalling
// receiver, tracks the drone state in a local fixed-point model and checks
// every result word field by field. Runs several register settings in turn.
// ----------------------------------------------------------------------------
module planar_drone_dynamics_step_test;

  localparam logic [1:0] CMD_SET  = pdds_pkg::CMD_SET;
  localparam logic [1:0] CMD_STEP = pdds_pkg::CMD_STEP;
  localparam logic [1:0] CMD_LOAD = pdds_pkg::CMD_LOAD;
  localparam logic [1:0] CMD_NONE = 2'd3;
  localparam int N_PHASE = 8;
  localparam int PHASE_WORDS = 250;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [135:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [191:0] m_axis_tdata;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [pdds_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [pdds_pkg::CFG_W-1:0]     cfg_data_i = '0;

  planar_drone_dynamics_step dut (.*);

  always #10 clk_i = ~clk_i;

  // one input word
  typedef struct {
    logic [1:0]  cmd;
    logic [31:0] a, b, c, d;
  } cmd_word_t;

  // directed rows: typed rows expect pos = (ex, ey) and all else zero
  typedef struct {
    logic [1:0]  cmd;
    logic [31:0] a, b, c, d;
    bit          typed;
    logic [31:0] ex, ey;
  } dir_row_t;

  // model of the drone and its registers
  longint reg_dt, reg_inv_m, reg_grav, reg_arm, reg_inv_j, reg_tmax, reg_tmin;
  int pos_x, pos_y, vel_x, vel_y, tilt, spin, thr_l, thr_r;

  logic [191:0] pending_res[$];
  int  errors = 0;
  int  words_sent = 0;
  int  results_seen = 0;
  int  hold_cycles = 0;
  int  burst_left = 0;

  longint atan_q30[24] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
    64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
    64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
    64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
  };

  string field_name[6] = '{"pos_x", "pos_y", "vel_x", "vel_y", "angle", "rate"};

  task automatic report(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    errors++;
  endtask

  function automatic int clip32(input longint v);
    if (v > 64'sh7FFFFFFF) return 32'sh7FFFFFFF;
    if (v < -64'sh80000000) return 32'sh80000000;
    return int'(v);
  endfunction

  // Q16.16 product, floor shift, clipped
  function automatic int qmul(input longint a, input longint b);
    longint p;
    p = a * b;
    return clip32(p >>> pdds_pkg::FRAC_BITS);
  endfunction

  function automatic int limit_thrust(input int f);
    longint t;
    t = (longint'(f) > reg_tmax) ? reg_tmax : longint'(f);
    if (t < reg_tmin) t = reg_tmin;
    return int'(t);
  endfunction

  // CORDIC sine and cosine of an angle reduced into (-pi, pi]
  task automatic tilt_trig(input int ang, output int s, output int c);
    longint r, x, y, z, nx;
    bit flip;
    r = longint'(ang) % pdds_pkg::TWO_PI_Q;
    if (r < 0) r += pdds_pkg::TWO_PI_Q;
    if (r > pdds_pkg::PI_Q) r -= pdds_pkg::TWO_PI_Q;
    z = r * (64'sd1 <<< (30 - pdds_pkg::FRAC_BITS));
    x = pdds_pkg::GAIN30;
    y = 0;
    flip = 1'b0;
    if (z > pdds_pkg::HALF_PI30) begin
      z -= pdds_pkg::PI30;
      flip = 1'b1;
    end else if (z < -pdds_pkg::HALF_PI30) begin
      z += pdds_pkg::PI30;
      flip = 1'b1;
    end
    for (int i = 0; i < pdds_pkg::TRIG_STEPS && i < 24; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z -= atan_q30[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z += atan_q30[i];
      end
      x = nx;
    end
    x = x >>> (30 - pdds_pkg::FRAC_BITS);
    y = y >>> (30 - pdds_pkg::FRAC_BITS);
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = clip32(x);
    s = clip32(y);
  endtask

  // apply one word to the model and return the state word it yields
  task automatic drone_update(input cmd_word_t w, output logic [191:0] res);
    int s, c, total, acc, torque;
    case (w.cmd)
      CMD_SET: begin
        thr_l = limit_thrust(w.a);
        thr_r = limit_thrust(w.b);
      end
      CMD_STEP: begin
        tilt_trig(tilt, s, c);
        total = clip32(longint'(thr_l) + thr_r);
        acc = qmul(qmul(total, s), reg_inv_m);
        vel_x = clip32(longint'(vel_x) + qmul(acc, reg_dt));
        acc = clip32(reg_grav - qmul(qmul(total, c), reg_inv_m));
        vel_y = clip32(longint'(vel_y) + qmul(acc, reg_dt));
        pos_x = clip32(longint'(pos_x) + qmul(vel_x, reg_dt));
        pos_y = clip32(longint'(pos_y) + qmul(vel_y, reg_dt));
        torque = qmul(clip32(longint'(thr_l) - thr_r), reg_arm);
        spin = clip32(longint'(spin) + qmul(qmul(torque, reg_inv_j), reg_dt));
        tilt = clip32(longint'(tilt) + qmul(spin, reg_dt));
      end
      CMD_LOAD: begin
        thr_l = 0; thr_r = 0; tilt = 0; spin = 0; vel_x = 0; vel_y = 0;
        pos_x = w.c;
        pos_y = w.d;
      end
      default: ;
    endcase
    res = {spin, tilt, vel_y, vel_x, pos_y, pos_x};
  endtask

  // register write, only issued while the block is idle
  task automatic write_reg(input logic [pdds_pkg::CFG_IDX_W-1:0] idx, input longint val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val[pdds_pkg::CFG_W-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      pdds_pkg::REG_TIME_STEP:   reg_dt    = val & 64'h7FFFFFFF;
      pdds_pkg::REG_INV_MASS:    reg_inv_m = val & 64'h7FFFFFFF;
      pdds_pkg::REG_GRAVITY:     reg_grav  = val & 64'h7FFFFFFF;
      pdds_pkg::REG_HALF_ARM:    reg_arm   = val & 64'h7FFFFFFF;
      pdds_pkg::REG_INV_INERTIA: reg_inv_j = val & 64'h7FFFFFFF;
      pdds_pkg::REG_THRUST_MAX:  reg_tmax  = val & 64'h7FFFFFFF;
      pdds_pkg::REG_THRUST_MIN:  reg_tmin  = val & 64'h7FFFFFFF;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // offer one word; a typed row overrides the model's expectation
  task automatic send_word(input cmd_word_t w, input bit typed, input logic [191:0] typed_res);
    logic [191:0] res;
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      if ($urandom_range(0, 2) != 0) gap = $urandom_range(1, 12);
    end
    burst_left--;
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, w.d, w.c, w.b, w.a, w.cmd};
    do @(posedge clk_i); while (!s_axis_tready);
    drone_update(w, res);
    pending_res.push_back(typed ? typed_res : res);
    words_sent++;
  endtask

  function automatic logic [31:0] rand_value(input int span);
    if ($urandom_range(0, 3) == 0) return $urandom;
    return $urandom_range(0, span);
  endfunction

  // mostly thrust-then-step flights, some loads and noise
  function automatic cmd_word_t rand_word();
    cmd_word_t w;
    int pick;
    pick = $urandom_range(0, 99);
    w.a = $urandom; w.b = $urandom; w.c = $urandom; w.d = $urandom;
    if (pick < 6) begin
      w.cmd = CMD_LOAD;
      if ($urandom_range(0, 1)) begin
        w.c = $urandom_range(0, 1 << 22) - (1 << 21);
        w.d = $urandom_range(0, 1 << 22) - (1 << 21);
      end
    end else if (pick < 30) begin
      w.cmd = CMD_SET;
      w.a = rand_value(1 << 21);
      w.b = rand_value(1 << 21);
    end else if (pick < 96) begin
      w.cmd = CMD_STEP;
    end else begin
      w.cmd = CMD_NONE;
    end
    return w;
  endfunction

  task automatic drain();
    wait (pending_res.size() == 0);
    repeat (8) @(posedge clk_i);
  endtask

  // register set for each phase
  task automatic set_regs(input int phase);
    longint v[7];
    longint tmax;
    case (phase)
      0: v = '{1092, 65536, 642908, 32768, 65536, 1157234, 128582};
      1: v = '{64'h7FFFFFFF, 64'h7FFFFFFF, 64'h7FFFFFFF, 64'h7FFFFFFF,
               64'h7FFFFFFF, 64'h7FFFFFFF, 64'h7FFFFFFF};
      2: v = '{0, 0, 0, 0, 0, 0, 0};
      // crossed clamps: the lower bound wins
      3: v = '{1092, 65536, 642908, 32768, 65536, 128582, 1157234};
      4: for (int i = 0; i < 7; i++) v[i] = $urandom & 32'h7FFFFFFF;
      default: begin
        tmax = $urandom_range(0, 1 << 22);
        v = '{$urandom_range(100, 20000), $urandom_range(16384, 262144),
              $urandom_range(0, 1 << 21), $urandom_range(0, 1 << 20),
              $urandom_range(16384, 1 << 20), tmax, $urandom_range(0, tmax)};
      end
    endcase
    write_reg(pdds_pkg::REG_TIME_STEP,   v[0]);
    write_reg(pdds_pkg::REG_INV_MASS,    v[1]);
    write_reg(pdds_pkg::REG_GRAVITY,     v[2]);
    write_reg(pdds_pkg::REG_HALF_ARM,    v[3]);
    write_reg(pdds_pkg::REG_INV_INERTIA, v[4]);
    write_reg(pdds_pkg::REG_THRUST_MAX,  v[5]);
    write_reg(pdds_pkg::REG_THRUST_MIN,  v[6]);
  endtask

  dir_row_t dir_tab[23] = '{
    '{CMD_NONE, 0, 0, 0, 0, 1'b1, 0, 0},
    '{CMD_STEP, 0, 0, 0, 0, 1'b0, 0, 0},
    '{CMD_LOAD, 0, 0, 32'h7FFFFFFF, 32'h80000000, 1'b1, 32'h7FFFFFFF, 32'h80000000},
    '{CMD_SET, 32'h7FFFFFFF, 32'h80000000, 0, 0, 1'b1, 32'h7FFFFFFF, 32'h80000000},
    '{CMD_STEP, 0, 0, 0, 0, 1'b0, 0, 0},
    '{CMD_STEP, 0, 0, 0, 0, 1'b0, 0, 0},
    '{CMD_SET, 32'h80000000, 32'h7FFFFFFF, 0, 0, 1'b0, 0, 0},
    '{CMD_STEP, 0, 0, 0, 0, 1'b0, 0, 0},
    '{CMD_STEP, 0, 0, 0, 0, 1'b0, 0, 0},
    '{CMD_STEP, 0, 0, 0, 0, 1'b0, 0, 0},
    '{CMD_STEP, 0, 0, 0, 0, 1'b0, 0, 0},
    '{CMD_NONE, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, 0, 0},
    '{CMD_LOAD, 32'hFFFFFFFF, 32'hFFFFFFFF, 0, 0, 1'b1, 0, 0},
    '{CMD_SET, 0, 0, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 0, 0},
    '{CMD_STEP, 0, 0, 0, 0, 1'b0, 0, 0},
    '{CMD_LOAD, 0, 0, 32'h12345678, 32'hEDCBA988, 1'b1, 32'h12345678, 32'hEDCBA988},
    '{CMD_SET, 32'h00100000, 32'h00080000, 0, 0, 1'b0, 0, 0},
    '{CMD_STEP, 0, 0, 0, 0, 1'b0, 0, 0},
    '{CMD_STEP, 0, 0, 0, 0, 1'b0, 0, 0},
    '{CMD_STEP, 0, 0, 0, 0, 1'b0, 0, 0},
    '{CMD_STEP, 0, 0, 0, 0, 1'b0, 0, 0},
    '{CMD_STEP, 0, 0, 0, 0, 1'b0, 0, 0},
    '{CMD_NONE, 0, 0, 0, 0, 1'b0, 0, 0}
  };

  // receiver: long hold-offs on request, otherwise a changing stall pattern
  always @(negedge clk_i) begin : rx_pace
    int cyc;
    cyc++;
    if (hold_cycles > 0) begin
      hold_cycles--;
      m_axis_tready <= 1'b0;
    end else begin
      case ((cyc / 300) % 3)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= ($urandom_range(0, 1) == 1);
        default: m_axis_tready <= ((cyc % 7) >= 3);
      endcase
    end
  end

  // result checker
  always @(posedge clk_i) begin
    logic [191:0] want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (pending_res.size() == 0) begin
        report("result word with none expected");
      end else begin
        want = pending_res.pop_front();
        for (int f = 0; f < 6; f++) begin
          if (m_axis_tdata[f*32 +: 32] !== want[f*32 +: 32]) begin
            report($sformatf("%s got %h want %h", field_name[f],
                             m_axis_tdata[f*32 +: 32], want[f*32 +: 32]));
          end
        end
      end
    end
  end

  // run limit
  initial begin
    #100_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    cmd_word_t w;
    logic [191:0] typed_res;
    reg_dt = 1092; reg_inv_m = 65536; reg_grav = 642908; reg_arm = 32768;
    reg_inv_j = 65536; reg_tmax = 1157234; reg_tmin = 128582;
    pos_x = 0; pos_y = 0; vel_x = 0; vel_y = 0; tilt = 0; spin = 0;
    thr_l = 0; thr_r = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed part at reset register values
    foreach (dir_tab[i]) begin
      w.cmd = dir_tab[i].cmd;
      w.a = dir_tab[i].a; w.b = dir_tab[i].b; w.c = dir_tab[i].c; w.d = dir_tab[i].d;
      typed_res = {128'd0, dir_tab[i].ey, dir_tab[i].ex};
      send_word(w, dir_tab[i].typed, typed_res);
    end

    // random phases, one register set each
    for (int p = 0; p < N_PHASE; p++) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      drain();
      set_regs(p);
      if (p == 5) hold_cycles = 3000;
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (p == 6 && n == 100) begin
          @(negedge clk_i);
          s_axis_tvalid <= 1'b0;
          wait (pending_res.size() == 0);
        end
        send_word(rand_word(), 1'b0, '0);
      end
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    wait (pending_res.size() == 0);
    repeat (600) @(posedge clk_i);

    $display("Sent %0d command words over %0d register sets, %0d results checked.",
             words_sent, N_PHASE + 1, results_seen);
    $display("Covered saturation, crossed clamps, angle wrap and receiver back-pressure.");
    if (errors == 0 && pending_res.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/pdds_pkg.sv
rtl/pdds_mul.sv
rtl/pdds_trig.sv
rtl/planar_drone_dynamics_step.sv
dv/planar_drone_dynamics_step_test.sv
